@@ hdl/sfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Structure factor accumulator package
// Shared widths, the queue entry type, the quadrant codes and the quarter-wave
// cosine and sine tables, which are built at elaboration.
// ----------------------------------------------------------------------------
package sfa_pkg;

	// Design constants
	localparam int MAX_ATOMS        = 1024;
	localparam int TABLE_INDEX_BITS = 10;
	localparam int COORD_FRAC_BITS  = 16;

	// Field widths
	localparam int COORD_W = 24;
	localparam int ACC_W   = 26;
	localparam int CNT_W   = 11;
	localparam int AMP_W   = 15;
	localparam int TERM_W  = AMP_W + 1;

	// Only the low 2*COORD_FRAC_BITS bits of the dot product reach the index:
	// everything above is whole turns.
	localparam int PROD_W   = 2 * COORD_FRAC_BITS;
	localparam int PH_SHIFT = PROD_W - TABLE_INDEX_BITS;
	localparam logic [PROD_W-1:0] PH_ROUND = PROD_W'(64'd1 << (PH_SHIFT - 1));

	localparam int QTR_BITS = TABLE_INDEX_BITS - 2;
	localparam int QTR      = 1 << QTR_BITS;

	localparam int CNT_CAP_INT = (MAX_ATOMS < 2047) ? MAX_ATOMS : 2047;
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_INT);

	localparam logic signed [ACC_W-1:0] ACC_LIM = ACC_W'(16777216);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	// Quadrant of the phase, from the top two index bits
	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	// One classified item as it waits between the front and the back
	typedef struct packed {
		logic [TABLE_INDEX_BITS-1:0] idx;
		logic                        last;
	} phase_t;

	typedef logic [AMP_W-1:0] amp_t;
	typedef amp_t [QTR-1:0]   amp_tbl_t;

	// Table construction, elaboration only
	localparam longint HALF_PI_Q30  = 64'sd1686629713;
	localparam longint Q30_ONE      = 64'sd1073741824;
	localparam longint Q29_HALF     = 64'sd536870912;
	localparam longint AMP_ONE      = 64'sd16384;
	localparam int     TAYLOR_TERMS = 12;

	localparam longint unsigned COS_DIV [TAYLOR_TERMS] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
		64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
	};
	localparam longint unsigned SIN_DIV [TAYLOR_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	function automatic amp_t q30_to_q14(input longint v);
		longint t;
		t = 0;
		if (v > 0) begin
			t = (v * AMP_ONE + Q29_HALF) >>> 30;
			if (t > AMP_ONE)
				t = AMP_ONE;
		end
		return AMP_W'(t);
	endfunction

	// Taylor series in Q30. Once a term truncates to zero every later one is
	// zero too, so a fixed number of terms gives the same sum.
	function automatic amp_t taylor_q14(input longint unsigned a2,
			input longint unsigned start, input logic want_sin);
		longint unsigned term;
		longint          sum;
		term = start;
		sum  = longint'(start);
		for (int i = 0; i < TAYLOR_TERMS; i++) begin
			if (want_sin)
				term = ((term * a2) >> 30) / SIN_DIV[i];
			else
				term = ((term * a2) >> 30) / COS_DIV[i];
			if ((i % 2) == 0)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		return q30_to_q14(sum);
	endfunction

	function automatic amp_tbl_t build_tbl(input logic want_sin);
		amp_tbl_t        tbl;
		longint unsigned a;
		longint unsigned a2;
		for (int r = 0; r < QTR; r++) begin
			a  = longint'((HALF_PI_Q30 * longint'(r) + longint'(QTR / 2)) / QTR);
			a2 = (a * a) >> 30;
			if (want_sin)
				tbl[r] = taylor_q14(a2, a, 1'b1);
			else
				tbl[r] = taylor_q14(a2, longint'(Q30_ONE), 1'b0);
		end
		return tbl;
	endfunction

	localparam amp_tbl_t COS_TBL = build_tbl(1'b0);
	localparam amp_tbl_t SIN_TBL = build_tbl(1'b1);

endpackage
`default_nettype wire

@@ hdl/sfa_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Structure factor front end
// Takes items in, forms the dot product of G and the position and rounds it
// to a table index of one turn, in two pipeline stages.
// ----------------------------------------------------------------------------
module sfa_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [sfa_pkg::COORD_W-1:0] g_x,
	input  wire logic signed [sfa_pkg::COORD_W-1:0] g_y,
	input  wire logic signed [sfa_pkg::COORD_W-1:0] g_z,
	input  wire logic signed [sfa_pkg::COORD_W-1:0] pos_x,
	input  wire logic signed [sfa_pkg::COORD_W-1:0] pos_y,
	input  wire logic signed [sfa_pkg::COORD_W-1:0] pos_z,
	input  wire logic                               last_atom,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output sfa_pkg::phase_t                         out_entry
);
	import sfa_pkg::*;

	logic signed [2*COORD_W-1:0] mul_x, mul_y, mul_z;
	logic [PROD_W-1:0]           prod_x_s1, prod_y_s1, prod_z_s1;
	logic                        last_s1, valid_s1;
	logic [PROD_W-1:0]           phase_sum;
	phase_t                      entry_s2;
	logic                        valid_s2;
	logic                        en_s1, en_s2;

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	// Only the low product bits survive the modulo-one-turn wrap.
	assign mul_x = g_x * pos_x;
	assign mul_y = g_y * pos_y;
	assign mul_z = g_z * pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_x_s1 <= mul_x[PROD_W-1:0];
			prod_y_s1 <= mul_y[PROD_W-1:0];
			prod_z_s1 <= mul_z[PROD_W-1:0];
			last_s1   <= last_atom;
		end
	end

	// Round half up to the table resolution.
	assign phase_sum = prod_x_s1 + prod_y_s1 + prod_z_s1 + PH_ROUND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			entry_s2.idx  <= phase_sum[PROD_W-1:PH_SHIFT];
			entry_s2.last <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_entry = entry_s2;

endmodule
`default_nettype wire

@@ hdl/sfa_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Structure factor phase queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module sfa_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_valid,
	output logic                 wr_ready,
	input  wire sfa_pkg::phase_t wr_data,
	output logic                 rd_valid,
	input  wire logic            rd_ready,
	output sfa_pkg::phase_t      rd_data
);
	import sfa_pkg::*;

	phase_t                mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_wr, do_rd;

	assign wr_ready = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Occupancy never runs past the depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("phase queue occupancy beyond its depth");

endmodule
`default_nettype wire

@@ hdl/sfa_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Structure factor back end
// Looks up cosine and sine for each queued phase, accumulates the complex sum
// with saturation and hands finished sums to a one-deep result register.
// ----------------------------------------------------------------------------
module sfa_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              q_valid,
	output logic                                   q_ready,
	input  wire sfa_pkg::phase_t                   q_entry,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic signed [sfa_pkg::ACC_W-1:0]       sf_real,
	output logic signed [sfa_pkg::ACC_W-1:0]       sf_imag,
	output logic [sfa_pkg::CNT_W-1:0]              atom_count,
	output logic                                   saturated
);
	import sfa_pkg::*;

	quad_t                    quad;
	logic [QTR_BITS-1:0]      ridx;
	logic signed [TERM_W-1:0] cos_t, sin_t;
	logic signed [TERM_W-1:0] re_term, im_term;
	logic signed [TERM_W-1:0] re_s1, im_s1;
	logic                     last_s1, valid_s1;
	logic                     en_s1, fire, out_take;

	logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     ovf_q;
	logic                     out_v_q;

	logic signed [ACC_W-1:0]  sum_re, sum_im, nx_re, nx_im;
	logic                     sat_re, sat_im, at_cap;
	logic [CNT_W-1:0]         nx_cnt;
	logic                     nx_ovf;

	// Lookup stage
	assign quad  = quad_t'(q_entry.idx[TABLE_INDEX_BITS-1 -: 2]);
	assign ridx  = q_entry.idx[QTR_BITS-1:0];
	assign cos_t = $signed({1'b0, COS_TBL[ridx]});
	assign sin_t = $signed({1'b0, SIN_TBL[ridx]});

	// Real term is the cosine, imaginary term minus the sine, per quadrant.
	always_comb begin
		unique case (quad)
			QUAD_I: begin
				re_term = cos_t;
				im_term = -sin_t;
			end
			QUAD_II: begin
				re_term = -sin_t;
				im_term = -cos_t;
			end
			QUAD_III: begin
				re_term = -cos_t;
				im_term = sin_t;
			end
			QUAD_IV: begin
				re_term = sin_t;
				im_term = cos_t;
			end
		endcase
	end

	// A last item waits in the lookup stage while the previous sum is unread.
	assign out_take = out_v_q && pop;
	assign fire     = valid_s1 && (!last_s1 || !out_v_q || out_take);
	assign en_s1    = !valid_s1 || fire;
	assign q_ready  = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			re_s1   <= re_term;
			im_s1   <= im_term;
			last_s1 <= q_entry.last;
		end
	end

	// Accumulate stage
	assign sum_re = acc_re_q + {{(ACC_W-TERM_W){re_s1[TERM_W-1]}}, re_s1};
	assign sum_im = acc_im_q + {{(ACC_W-TERM_W){im_s1[TERM_W-1]}}, im_s1};

	always_comb begin
		sat_re = 1'b1;
		if (sum_re > ACC_LIM)
			nx_re = ACC_LIM;
		else if (sum_re < -ACC_LIM)
			nx_re = -ACC_LIM;
		else begin
			nx_re  = sum_re;
			sat_re = 1'b0;
		end
		sat_im = 1'b1;
		if (sum_im > ACC_LIM)
			nx_im = ACC_LIM;
		else if (sum_im < -ACC_LIM)
			nx_im = -ACC_LIM;
		else begin
			nx_im  = sum_im;
			sat_im = 1'b0;
		end
	end

	assign at_cap = (cnt_q >= CNT_CAP);
	assign nx_cnt = at_cap ? cnt_q : cnt_q + 1'b1;
	assign nx_ovf = ovf_q || at_cap || sat_re || sat_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				acc_re_q <= '0;
				acc_im_q <= '0;
				cnt_q    <= '0;
				ovf_q    <= 1'b0;
			end else begin
				acc_re_q <= nx_re;
				acc_im_q <= nx_im;
				cnt_q    <= nx_cnt;
				ovf_q    <= nx_ovf;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_v_q <= 1'b1;
		end else if (out_take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			sf_real    <= nx_re;
			sf_imag    <= nx_im;
			atom_count <= nx_cnt;
			saturated  <= nx_ovf;
		end
	end

	assign empty = !out_v_q;

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_CAP)
		else $error("atom count above its cap");

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_re_q <= ACC_LIM && acc_re_q >= -ACC_LIM &&
		acc_im_q <= ACC_LIM && acc_im_q >= -ACC_LIM)
		else $error("accumulator outside the saturation range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !pop) |-> !(fire && last_s1))
		else $error("unread sum overwritten");

endmodule
`default_nettype wire

@@ hdl/structure_factor_accumulator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Structure factor accumulator
// Sums exp(-i 2 pi G.tau) over a stream of atoms and returns one complex
// structure factor per group of atoms.
// ----------------------------------------------------------------------------
// Each item carries one reciprocal vector G/(2 pi) and one atom position, both
// signed Q8.16, plus a flag that marks the last atom of a sum. The block takes
// one item every clock cycle while full is low. The dot product is formed in a
// two-stage front end (three multipliers, then a sum and rounding to a 10-bit
// index of one turn), the index waits in a four-entry queue, and the back end
// looks up cosine and sine in quarter-wave Q1.14 tables and adds cos and minus
// sin into two saturating accumulators. On an item with last_atom set the sums,
// the atom count and the saturation flag appear on the result side and the
// accumulators restart from zero with the next item. A result passes through
// the front stages, the queue, the lookup stage and the result register, and
// stays until popped; other items keep flowing in the meantime. Only a second
// last item arriving while a sum is still unread stalls the back end, and full
// rises once the queue and both front stages are occupied. saturated reports
// more atoms than the supported 1024, or a sum clamped at plus or minus 2^24.
// ----------------------------------------------------------------------------
module structure_factor_accumulator_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic signed [sfa_pkg::COORD_W-1:0] g_x,
	input  wire logic signed [sfa_pkg::COORD_W-1:0] g_y,
	input  wire logic signed [sfa_pkg::COORD_W-1:0] g_z,
	input  wire logic signed [sfa_pkg::COORD_W-1:0] pos_x,
	input  wire logic signed [sfa_pkg::COORD_W-1:0] pos_y,
	input  wire logic signed [sfa_pkg::COORD_W-1:0] pos_z,
	input  wire logic                               last_atom,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic signed [sfa_pkg::ACC_W-1:0]        sf_real,
	output logic signed [sfa_pkg::ACC_W-1:0]        sf_imag,
	output logic [sfa_pkg::CNT_W-1:0]               atom_count,
	output logic                                    saturated
);
	import sfa_pkg::*;

	logic   front_ready;
	logic   front_valid;
	phase_t front_entry;
	logic   fifo_ready;
	logic   back_valid;
	logic   back_ready;
	phase_t back_entry;

	// The front end stalls only when its output cannot enter the queue.
	assign full = !front_ready;

	sfa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push),
		.in_ready  (front_ready),
		.g_x       (g_x),
		.g_y       (g_y),
		.g_z       (g_z),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.last_atom (last_atom),
		.out_valid (front_valid),
		.out_ready (fifo_ready),
		.out_entry (front_entry)
	);

	// The queue lets the front keep taking items while the back waits for a
	// result to be read.
	sfa_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (fifo_ready),
		.wr_data  (front_entry),
		.rd_valid (back_valid),
		.rd_ready (back_ready),
		.rd_data  (back_entry)
	);

	sfa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (back_valid),
		.q_ready    (back_ready),
		.q_entry    (back_entry),
		.empty      (empty),
		.pop        (pop),
		.sf_real    (sf_real),
		.sf_imag    (sf_imag),
		.atom_count (atom_count),
		.saturated  (saturated)
	);

endmodule
`default_nettype wire

@@ tb/structure_factor_accumulator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Structure factor accumulator testbench
// Streams atoms through the accumulator under random sender gaps and receiver
// stalls, predicts every complex sum in fixed point and checks each popped
// result against the oldest prediction.
// ----------------------------------------------------------------------------
module structure_factor_accumulator_top_tb;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 5;
	localparam int DRAIN_CYCLES   = 24;
	localparam int TIMEOUT_CYCLES = 1000000;
	localparam int RANDOM_ATOMS   = 500;
	localparam int MAX_REPORTS    = 10;

	localparam int COORD_W  = sfa_pkg::COORD_W;
	localparam int ACC_W    = sfa_pkg::ACC_W;
	localparam int CNT_W    = sfa_pkg::CNT_W;

	// Phase index layout: TBL_BITS fraction bits of a turn, the top two of
	// which select the quadrant of the quarter-wave tables.
	localparam int TBL_BITS  = sfa_pkg::TABLE_INDEX_BITS;
	localparam int QTR_BITS  = TBL_BITS - 2;
	localparam int QTR_SIZE  = 1 << QTR_BITS;
	localparam int PHASE_LSB = 2 * sfa_pkg::COORD_FRAC_BITS - TBL_BITS;
	localparam logic [63:0] PHASE_HALF = 64'd1 << (PHASE_LSB - 1);

	// A coordinate of 1.0 and the position step that moves the phase by one
	// table entry when it is multiplied by that 1.0.
	localparam logic signed [COORD_W-1:0] COORD_ONE = 24'sd1 << sfa_pkg::COORD_FRAC_BITS;
	localparam int PHASE_STEP_SHIFT = PHASE_LSB - sfa_pkg::COORD_FRAC_BITS;

	localparam int     ATOM_CAP   = (sfa_pkg::MAX_ATOMS < 2047) ? sfa_pkg::MAX_ATOMS : 2047;
	localparam longint SUM_LIMIT  = 64'sd16777216;
	localparam longint AMP_FULL   = 64'sd16384;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

	typedef struct packed {
		logic signed [COORD_W-1:0] gx;
		logic signed [COORD_W-1:0] gy;
		logic signed [COORD_W-1:0] gz;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
		logic                      last;
	} atom_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] re;
		logic signed [ACC_W-1:0] im;
		logic [CNT_W-1:0]        atoms;
		logic                    sat;
	} sf_sum_t;

	// How the coordinates of one random sum are drawn
	typedef enum int {
		SUM_FULL,
		SUM_SMALL,
		SUM_EXTREME,
		SUM_PHASE
	} sum_style_t;

	// Receiver behaviour, switched at random by the pop driver
	typedef enum int {
		RX_EAGER,
		RX_RANDOM,
		RX_SPARSE,
		RX_BLOCKED
	} rx_mode_t;

	// Every input is known from time zero.
	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      push      = 1'b0;
	logic signed [COORD_W-1:0] g_x       = '0;
	logic signed [COORD_W-1:0] g_y       = '0;
	logic signed [COORD_W-1:0] g_z       = '0;
	logic signed [COORD_W-1:0] pos_x     = '0;
	logic signed [COORD_W-1:0] pos_y     = '0;
	logic signed [COORD_W-1:0] pos_z     = '0;
	logic                      last_atom = 1'b0;
	logic                      pop       = 1'b0;
	logic                      full;
	logic                      empty;
	logic signed [ACC_W-1:0]   sf_real;
	logic signed [ACC_W-1:0]   sf_imag;
	logic [CNT_W-1:0]          atom_count;
	logic                      saturated;

	structure_factor_accumulator_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.g_x        (g_x),
		.g_y        (g_y),
		.g_z        (g_z),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.last_atom  (last_atom),
		.empty      (empty),
		.pop        (pop),
		.sf_real    (sf_real),
		.sf_imag    (sf_imag),
		.atom_count (atom_count),
		.saturated  (saturated)
	);

	// Quarter-wave amplitude tables of the predictor, Q1.14.
	longint cos_q14 [QTR_SIZE];
	longint sin_q14 [QTR_SIZE];

	// Running sum of the predictor; it mirrors the block's accumulators.
	longint      sum_re;
	longint      sum_im;
	int unsigned atoms_in_sum;
	bit          sum_saturated;

	// Sums predicted but not yet popped, oldest first.
	sf_sum_t expected_sums [$];

	int unsigned atoms_sent    = 0;
	int unsigned sums_checked  = 0;
	int unsigned sums_flagged  = 0;
	int unsigned mismatches    = 0;
	int unsigned burst_left    = 0;
	rx_mode_t    rx_mode       = RX_EAGER;

	// ------------------------------------------------------------------------
	// Clock and run limit
	// ------------------------------------------------------------------------
	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// A correct run ends well before this limit, even with every sum waiting
	// out the longest receiver stall.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Timed out with %0d sums still outstanding.", expected_sums.size());
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Alternating Taylor series in Q30. The first term is the angle for the
	// sine and 1.0 for the cosine; the series stops once a term truncates to
	// zero, since every later one would be zero as well.
	function automatic longint series_q30(input longint unsigned a2,
			input longint unsigned first, input longint unsigned k0);
		longint          acc;
		longint unsigned term;
		longint unsigned k;
		bit              subtract;
		acc      = longint'(first);
		term     = first;
		k        = k0;
		subtract = 1'b1;
		while (term != 0) begin
			term = ((term * a2) >> 30) / (k * (k + 1));
			if (subtract)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
			subtract = !subtract;
			k        = k + 2;
		end
		return acc;
	endfunction

	// Q30 to Q1.14 with rounding, held within 0 to 1.0.
	function automatic longint amp_from_q30(input longint v);
		longint t;
		if (v <= 0)
			return 0;
		t = (v * AMP_FULL + (64'sd1 <<< 29)) >>> 30;
		return (t > AMP_FULL) ? AMP_FULL : t;
	endfunction

	task automatic build_trig_tables();
		longint unsigned angle;
		longint unsigned angle_sq;
		for (int r = 0; r < QTR_SIZE; r++) begin
			angle    = longint'((HALF_PI_Q30 * r + QTR_SIZE / 2) / QTR_SIZE);
			angle_sq = (angle * angle) >> 30;
			sin_q14[r] = amp_from_q30(series_q30(angle_sq, angle, 2));
			cos_q14[r] = amp_from_q30(series_q30(angle_sq, 64'd1 << 30, 1));
		end
	endtask

	function automatic longint clamp_sum(input longint v);
		if (v > SUM_LIMIT)
			return SUM_LIMIT;
		if (v < -SUM_LIMIT)
			return -SUM_LIMIT;
		return v;
	endfunction

	// Adds the phase term of one accepted atom and, on the last atom of a
	// sum, files the finished sum as the next expected result.
	task automatic accumulate_atom(input atom_t a);
		longint               dot;
		logic [63:0]          phase;
		logic [TBL_BITS-1:0]  idx;
		logic [QTR_BITS-1:0]  r;
		sfa_pkg::quad_t       quad;
		longint               c;
		longint               s;
		longint               raw;
		sf_sum_t              done;
		dot = longint'($signed(a.gx)) * longint'($signed(a.px))
			+ longint'($signed(a.gy)) * longint'($signed(a.py))
			+ longint'($signed(a.gz)) * longint'($signed(a.pz));
		// Round half up to a table step; whole turns fall off the top.
		phase = dot + PHASE_HALF;
		idx   = phase[PHASE_LSB +: TBL_BITS];
		quad  = sfa_pkg::quad_t'(idx[TBL_BITS-1 -: 2]);
		r     = idx[QTR_BITS-1:0];
		case (quad)
			sfa_pkg::QUAD_I: begin
				c = cos_q14[r];
				s = sin_q14[r];
			end
			sfa_pkg::QUAD_II: begin
				c = -sin_q14[r];
				s = cos_q14[r];
			end
			sfa_pkg::QUAD_III: begin
				c = -cos_q14[r];
				s = -sin_q14[r];
			end
			default: begin
				c = sin_q14[r];
				s = -cos_q14[r];
			end
		endcase

		// Past the atom limit the count sticks, but the term is still added.
		if (atoms_in_sum >= ATOM_CAP)
			sum_saturated = 1'b1;
		else
			atoms_in_sum++;
		raw    = sum_re + c;
		sum_re = clamp_sum(raw);
		if (sum_re != raw)
			sum_saturated = 1'b1;
		raw    = sum_im - s;
		sum_im = clamp_sum(raw);
		if (sum_im != raw)
			sum_saturated = 1'b1;

		if (a.last) begin
			done.re    = sum_re[ACC_W-1:0];
			done.im    = sum_im[ACC_W-1:0];
			done.atoms = atoms_in_sum[CNT_W-1:0];
			done.sat   = sum_saturated;
			expected_sums = {expected_sums, done};
			if (sum_saturated)
				sums_flagged++;
			sum_re        = 0;
			sum_im        = 0;
			atoms_in_sum  = 0;
			sum_saturated = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------

	// Items go out in bursts of random length. Most bursts are preceded by a
	// gap; about one in four follows straight on, so long unbroken streams
	// occur as well.
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if ($urandom_range(0, 3) != 0) begin
				gap  = $urandom_range(1, 10);
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// Presents one atom and holds it until the block takes it. push is left
	// high on return so that the next atom can follow without a bubble.
	task automatic send_atom(input atom_t a);
		pace_sender();
		push      <= 1'b1;
		g_x       <= a.gx;
		g_y       <= a.gy;
		g_z       <= a.gz;
		pos_x     <= a.px;
		pos_y     <= a.py;
		pos_z     <= a.pz;
		last_atom <= a.last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		accumulate_atom(a);
		atoms_sent++;
	endtask

	function automatic atom_t make_atom(input logic signed [COORD_W-1:0] gx,
			input logic signed [COORD_W-1:0] gy, input logic signed [COORD_W-1:0] gz,
			input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py,
			input logic signed [COORD_W-1:0] pz, input logic last);
		atom_t a;
		a.gx   = gx;
		a.gy   = gy;
		a.gz   = gz;
		a.px   = px;
		a.py   = py;
		a.pz   = pz;
		a.last = last;
		return a;
	endfunction

	// An atom whose phase is set by pos_x alone: with G = (1, 0, 0) one step
	// of 2^PHASE_STEP_SHIFT in pos_x moves the index by one table entry.
	// pos_y and pos_z are random but multiply a zero.
	function automatic atom_t phase_atom(input logic signed [COORD_W-1:0] px,
			input logic last);
		return make_atom(COORD_ONE, '0, '0, px, COORD_W'($urandom), COORD_W'($urandom), last);
	endfunction

	function automatic logic signed [COORD_W-1:0] pick_coord(input sum_style_t style);
		int v;
		v = $urandom;
		case (style)
			SUM_SMALL:
				return COORD_W'(v >>> $urandom_range(6, 30));
			SUM_EXTREME: begin
				case ($urandom_range(0, 5))
					0: return COORD_MAX;
					1: return COORD_MIN;
					2: return '0;
					3: return '1;
					4: return 24'sd1;
					default: return COORD_W'(v);
				endcase
			end
			default:
				return COORD_W'(v);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Receiver and result check
	// ------------------------------------------------------------------------

	// The receiver switches at random between four habits: taking everything,
	// random stalls, short windows, and long blocks that let the block fill up
	// and raise full.
	initial begin : drive_pop
		int unsigned cyc;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if ((cyc % 256) == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_EAGER:   pop <= 1'b1;
				RX_RANDOM:  pop <= ($urandom_range(0, 3) != 0);
				RX_SPARSE:  pop <= ((cyc % 7) < 2);
				default:    pop <= ((cyc % 64) < 8);
			endcase
		end
	end

	task automatic note_mismatch(input string what, input sf_sum_t want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: expected re=%0d im=%0d atoms=%0d sat=%0b, got re=%0d im=%0d atoms=%0d sat=%0b",
				$realtime, what, want.re, want.im, want.atoms, want.sat,
				sf_real, sf_imag, atom_count, saturated);
	endtask

	// Outputs are sampled at the edge that accepts them, before the block
	// moves on to its next result.
	always @(posedge clk) begin : check_sums
		sf_sum_t want;
		if (arst_n && pop && !empty) begin
			if (expected_sums.size() == 0) begin
				want = '0;
				note_mismatch("result with no sum outstanding", want);
			end else begin
				want = expected_sums.pop_front();
				sums_checked++;
				if (sf_real !== want.re || sf_imag !== want.im
						|| atom_count !== want.atoms || saturated !== want.sat)
					note_mismatch("wrong sum", want);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Single-atom sums at the corners of the coordinate range, where the dot
	// product is largest and its sign bits reach the top, followed by one
	// short sum of extremes.
	task automatic test_field_extremes();
		send_atom(make_atom('0, '0, '0, '0, '0, '0, 1'b1));
		send_atom(make_atom(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
		send_atom(make_atom(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
		send_atom(make_atom(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
		send_atom(make_atom(COORD_MIN, COORD_MAX, '1, COORD_MAX, COORD_MIN, '1, 1'b1));
		send_atom(make_atom(COORD_MIN, '0, '0, COORD_MIN, '0, '0, 1'b1));
		send_atom(make_atom(COORD_MAX, COORD_MIN, 24'sd1, COORD_MIN, '1, COORD_MAX, 1'b0));
		send_atom(make_atom(COORD_MIN, COORD_MIN, COORD_MAX, 24'sd1, COORD_MAX, COORD_MIN, 1'b0));
		send_atom(make_atom('0, '0, '0, '0, '0, '0, 1'b1));
	endtask

	// Every quadrant and its edges, then the rounding of a phase that sits
	// exactly half a table step from an entry, on both sides of zero.
	task automatic test_phase_quadrants();
		int unsigned marks [11] = '{0, 1, 127, 128, 255, 256, 511, 512, 767, 768, 1023};
		int          half;
		half = 1 << (PHASE_STEP_SHIFT - 1);
		foreach (marks[i])
			send_atom(phase_atom(COORD_W'(marks[i] << PHASE_STEP_SHIFT), 1'b1));
		send_atom(phase_atom(COORD_W'(half - 1), 1'b1));
		send_atom(phase_atom(COORD_W'(half), 1'b1));
		send_atom(phase_atom(COORD_W'(-half), 1'b1));
		send_atom(phase_atom(COORD_W'(-half - 1), 1'b1));
	endtask

	// One sum runs a few atoms past the atom limit along the imaginary axis.
	// At the limit the sum sits exactly on its bound without clamping; the
	// atoms after that leave the count stuck and clamp the sum.
	task automatic test_atom_limit();
		int unsigned mark;
		int unsigned n;
		int          jitter;
		mark = ($urandom_range(0, 1) != 0) ? 768 : 256;
		n    = ATOM_CAP + $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			jitter = int'($urandom_range(0, 63)) - 32;
			send_atom(phase_atom(COORD_W'(int'(mark << PHASE_STEP_SHIFT) + jitter), i == n - 1));
		end
	endtask

	// Sums of random length, mostly short so that results come often and the
	// result side backs up. Each sum draws its coordinates in one style:
	// anything at all, small magnitudes, extremes, or phases aimed at random
	// table entries.
	task automatic test_random_sums();
		int unsigned randomised;
		int unsigned len;
		int unsigned pick;
		sum_style_t  style;
		atom_t       a;
		randomised = 0;
		while (randomised < RANDOM_ATOMS) begin
			style = sum_style_t'($urandom_range(0, 3));
			pick  = $urandom_range(0, 9);
			if (pick < 6)
				len = $urandom_range(1, 4);
			else if (pick < 9)
				len = $urandom_range(5, 30);
			else
				len = $urandom_range(31, 200);
			for (int i = 0; i < len; i++) begin
				if (style == SUM_PHASE)
					a = phase_atom(COORD_W'(int'($urandom_range(0, (1 << TBL_BITS) - 1)
						<< PHASE_STEP_SHIFT) + int'($urandom_range(0, 63)) - 32), i == len - 1);
				else
					a = make_atom(pick_coord(style), pick_coord(style), pick_coord(style),
						pick_coord(style), pick_coord(style), pick_coord(style), i == len - 1);
				send_atom(a);
				randomised++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : run_tests
		int unsigned drain_wait;
		build_trig_tables();
		sum_re        = 0;
		sum_im        = 0;
		atoms_in_sum  = 0;
		sum_saturated = 1'b0;

		// The tables of the block are constants, so no clearing pass follows
		// reset.
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_phase_quadrants();
		test_atom_limit();
		test_random_sums();

		// Every sum ends on a last atom, so nothing is left half accumulated.
		push <= 1'b0;
		drain_wait = 0;
		while (expected_sums.size() != 0 && drain_wait < TIMEOUT_CYCLES) begin
			@(posedge clk);
			drain_wait++;
		end
		// A further wait catches any result that should not be there.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_sums.size() != 0) begin
			mismatches++;
			$display("%0d expected sums never arrived.", expected_sums.size());
		end

		$display("Sent %0d atoms and checked %0d complex sums, %0d of them saturated.",
			atoms_sent, sums_checked, sums_flagged);
		$display("Mismatches counted: %0d.", mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
